// ===== src/ipv_pkg.sv =====
// Shared types, constants and the CRC step function for the input packet validator.
package ipv_pkg;

   // Packet layout: byte offsets of each field.
   localparam logic [4:0] POS_VERSION     = 5'd4;
   localparam logic [4:0] POS_RSVD_LAST   = 5'd7;
   localparam logic [4:0] POS_EPOCH_LAST  = 5'd11;
   localparam logic [4:0] POS_COUNT_LAST  = 5'd15;
   localparam logic [4:0] POS_SLOT        = 5'd16;
   localparam logic [4:0] POS_FLAG        = 5'd17;
   localparam logic [4:0] POS_BTN_LAST    = 5'd19;
   localparam logic [4:0] POS_STICK_H     = 5'd20;
   localparam logic [4:0] POS_STICK_V     = 5'd21;
   localparam logic [4:0] POS_CRC_FIRST   = 5'd22;
   localparam logic [4:0] POS_LAST        = 5'd23;
   localparam logic [4:0] POS_MAX         = 5'd31;

   // Fixed content checks.
   localparam logic [31:0] MAGIC_WORD     = 32'h4D49_4E50;
   localparam logic [7:0]  FLAG_VALUE     = 8'h01;
   localparam logic [7:0]  SLOT_LIMIT     = 8'd4;
   localparam logic [7:0]  VERSION_RESET  = 8'h01;

   // CRC-16/CCITT, MSB first, no final xor.
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;

   // Verdict word handed from the front end to the back end.
   typedef struct packed {
      logic        ok;
      logic [31:0] epoch;
      logic [31:0] counter;
      logic [1:0]  slot;
      logic [15:0] buttons;
      logic [7:0]  stick_h;
      logic [7:0]  stick_v;
   } verdict_type;

   // Magic byte expected at offsets 0 through 3.
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = MAGIC_WORD[31:24];
         2'd1:    val = MAGIC_WORD[23:16];
         2'd2:    val = MAGIC_WORD[15:8];
         default: val = MAGIC_WORD[7:0];
      endcase
      return val;
   endfunction

   // One byte of CRC update, eight shift steps unrolled.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== src/input_packet_validator.sv =====
// Top level of the input packet validator: front end, verdict queue and back end.
// Throughput: one byte word per cycle, sustained, as long as the verdict queue has room.
// Path to the ports: the verdict queue is written at the edge that takes the marked final byte,
// and the output register loads it from the queue once that register is free or being drained.
// Reset (synchronous, active high) clears packet state, empties queue and output,
// and sets the expected version to 1.
module input_packet_validator import ipv_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_end_of_packet,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_packet_ok,
   output logic [31:0]        rsp_session_epoch,
   output logic [31:0]        rsp_frame_counter,
   output logic [1:0]         rsp_player_slot,
   output logic [15:0]        rsp_button_bits,
   output logic signed [7:0]  rsp_stick_horizontal,
   output logic signed [7:0]  rsp_stick_vertical,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data
);

   logic        q_full, q_push, q_pop, q_empty;
   verdict_type q_in_word, q_out_word;

   // Byte parsing and checking.
   ipv_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .req_end_of_packet (req_end_of_packet),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_word            (q_in_word)
   );

   // Verdicts waiting for the result side.
   ipv_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_in_word),
      .full      (q_full),
      .pop       (q_pop),
      .head_word (q_out_word),
      .empty     (q_empty)
   );

   // Result formation and output register.
   ipv_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_word               (q_out_word),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_packet_ok        (rsp_packet_ok),
      .rsp_session_epoch    (rsp_session_epoch),
      .rsp_frame_counter    (rsp_frame_counter),
      .rsp_player_slot      (rsp_player_slot),
      .rsp_button_bits      (rsp_button_bits),
      .rsp_stick_horizontal (rsp_stick_horizontal),
      .rsp_stick_vertical   (rsp_stick_vertical)
   );

endmodule

// ===== src/ipv_front.sv =====
// Front end: accepts packet bytes, checks and captures fields, and issues one verdict per packet.
module ipv_front import ipv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_packet,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        q_full,
   output logic        q_push,
   output verdict_type q_word
);

   logic [4:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        bad_ff, bad_in;
   logic [31:0] epoch_ff, epoch_in;
   logic [31:0] counter_ff, counter_in;
   logic [7:0]  slot_ff, slot_in;
   logic [15:0] buttons_ff, buttons_in;
   logic [7:0]  stick_h_ff, stick_h_in;
   logic [7:0]  stick_v_ff, stick_v_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  version_ff, version_in;
   logic        accept;
   logic [15:0] rx_crc_final;

   // A word is taken whenever the verdict queue has room.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // The version register follows the configuration port.
   assign version_in = csr_write_enable ? csr_write_data : version_ff;

   // The received CRC as it stands once the final byte is included.
   assign rx_crc_final = {rx_crc_ff[7:0], req_data_byte};

   // Verdict for the packet that ends with this word.
   always_comb begin
      q_push          = accept && req_end_of_packet;
      q_word.ok       = !bad_ff && (pos_ff == POS_LAST) && (rx_crc_final == crc_ff)
                        && (epoch_ff != 32'd0) && (slot_ff < SLOT_LIMIT);
      q_word.epoch    = epoch_ff;
      q_word.counter  = counter_ff;
      q_word.slot     = slot_ff[1:0];
      q_word.buttons  = buttons_ff;
      q_word.stick_h  = stick_h_ff;
      q_word.stick_v  = stick_v_ff;
   end

   // Field checks and captures by byte offset.
   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      bad_in     = bad_ff;
      epoch_in   = epoch_ff;
      counter_in = counter_ff;
      slot_in    = slot_ff;
      buttons_in = buttons_ff;
      stick_h_in = stick_h_ff;
      stick_v_in = stick_v_ff;
      rx_crc_in  = rx_crc_ff;
      if (accept) begin
         case (pos_ff) inside
            [5'd0:5'd3]: begin
               if (req_data_byte != magic_byte(pos_ff[1:0])) bad_in = 1'b1;
            end
            POS_VERSION: begin
               if (req_data_byte != version_ff) bad_in = 1'b1;
            end
            [5'd5:POS_RSVD_LAST]: begin
               if (req_data_byte != 8'd0) bad_in = 1'b1;
            end
            [5'd8:POS_EPOCH_LAST]: begin
               epoch_in = {epoch_ff[23:0], req_data_byte};
            end
            [5'd12:POS_COUNT_LAST]: begin
               counter_in = {counter_ff[23:0], req_data_byte};
            end
            POS_SLOT: begin
               slot_in = req_data_byte;
            end
            POS_FLAG: begin
               if (req_data_byte != FLAG_VALUE) bad_in = 1'b1;
            end
            [5'd18:POS_BTN_LAST]: begin
               buttons_in = {buttons_ff[7:0], req_data_byte};
            end
            POS_STICK_H: begin
               stick_h_in = req_data_byte;
            end
            POS_STICK_V: begin
               stick_v_in = req_data_byte;
            end
            [POS_CRC_FIRST:POS_LAST]: begin
               rx_crc_in = rx_crc_final;
            end
            default: begin
               bad_in = 1'b1;
            end
         endcase

         // The CRC covers the bytes ahead of the CRC field only.
         if (pos_ff < POS_CRC_FIRST) crc_in = crc16_byte(crc_ff, req_data_byte);

         // The position saturates on overlong packets.
         if (pos_ff != POS_MAX) pos_in = pos_ff + 5'd1;

         // A marked word closes the packet and clears all packet state.
         if (req_end_of_packet) begin
            pos_in     = 5'd0;
            crc_in     = CRC_INIT;
            bad_in     = 1'b0;
            epoch_in   = 32'd0;
            counter_in = 32'd0;
            slot_in    = 8'd0;
            buttons_in = 16'd0;
            stick_h_in = 8'd0;
            stick_v_in = 8'd0;
            rx_crc_in  = 16'd0;
         end
      end
   end

   // Packet state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 5'd0;
         crc_ff     <= CRC_INIT;
         bad_ff     <= 1'b0;
         epoch_ff   <= 32'd0;
         counter_ff <= 32'd0;
         slot_ff    <= 8'd0;
         buttons_ff <= 16'd0;
         stick_h_ff <= 8'd0;
         stick_v_ff <= 8'd0;
         rx_crc_ff  <= 16'd0;
         version_ff <= VERSION_RESET;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         bad_ff     <= bad_in;
         epoch_ff   <= epoch_in;
         counter_ff <= counter_in;
         slot_ff    <= slot_in;
         buttons_ff <= buttons_in;
         stick_h_ff <= stick_h_in;
         stick_v_ff <= stick_v_in;
         rx_crc_ff  <= rx_crc_in;
         version_ff <= version_in;
      end
   end

endmodule

// ===== src/ipv_queue.sv =====
// Small verdict queue that decouples the front end from the back end.
module ipv_queue import ipv_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  verdict_type push_word,
   output logic        full,
   input  logic        pop,
   output verdict_type head_word,
   output logic        empty
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   verdict_type     slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_wr, do_rd;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_wr     = push && !full;
   assign do_rd     = pop && !empty;
   assign head_word = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== src/ipv_back.sv =====
// Back end: forms the result word from a verdict and holds it in the output register.
module ipv_back import ipv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  verdict_type        q_word,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_packet_ok,
   output logic [31:0]        rsp_session_epoch,
   output logic [31:0]        rsp_frame_counter,
   output logic [1:0]         rsp_player_slot,
   output logic [15:0]        rsp_button_bits,
   output logic signed [7:0]  rsp_stick_horizontal,
   output logic signed [7:0]  rsp_stick_vertical
);

   logic        valid_ff, valid_in;
   verdict_type out_ff, out_in;
   logic        load;

   // Load a new verdict whenever the output register is free or being drained.
   assign load  = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop = load;

   // A failed packet reports every field as zero.
   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (load) begin
         valid_in = 1'b1;
         out_in   = q_word.ok ? q_word : '0;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty            = !valid_ff;
   assign rsp_packet_ok        = out_ff.ok;
   assign rsp_session_epoch    = out_ff.epoch;
   assign rsp_frame_counter    = out_ff.counter;
   assign rsp_player_slot      = out_ff.slot;
   assign rsp_button_bits      = out_ff.buttons;
   assign rsp_stick_horizontal = $signed(out_ff.stick_h);
   assign rsp_stick_vertical   = $signed(out_ff.stick_v);

endmodule

// ===== src/ipv_checker.sv =====
// Port-level checker for the input packet validator and its bind statement.
module ipv_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_full,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic               rsp_packet_ok,
   input  logic [31:0]        rsp_session_epoch,
   input  logic [31:0]        rsp_frame_counter,
   input  logic [1:0]         rsp_player_slot,
   input  logic [15:0]        rsp_button_bits,
   input  logic signed [7:0]  rsp_stick_horizontal,
   input  logic signed [7:0]  rsp_stick_vertical
);

   // Reset leaves no result word waiting and the input open.
   assert property (@(posedge clock) $past(reset) |-> (rsp_empty && !req_full))
      else $error("result word present or input blocked right after reset");

   // A failed packet reports every field as zero.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_packet_ok) |->
         (rsp_session_epoch == 32'd0 && rsp_frame_counter == 32'd0 &&
          rsp_player_slot == 2'd0 && rsp_button_bits == 16'd0 &&
          rsp_stick_horizontal == 8'sd0 && rsp_stick_vertical == 8'sd0))
      else $error("failed packet reports nonzero fields");

   // A passing packet always carries a nonzero epoch.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_packet_ok) |-> (rsp_session_epoch != 32'd0))
      else $error("passing packet with zero epoch");

   // A result word that is not taken stays in place, with flag, epoch, counter and buttons unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_packet_ok) && $stable(rsp_session_epoch) &&
          $stable(rsp_frame_counter) && $stable(rsp_button_bits)))
      else $error("held result word changed");

endmodule

bind input_packet_validator ipv_checker u_ipv_checker (
   .clock                (clock),
   .reset                (reset),
   .req_full             (req_full),
   .rsp_empty            (rsp_empty),
   .rsp_pop              (rsp_pop),
   .rsp_packet_ok        (rsp_packet_ok),
   .rsp_session_epoch    (rsp_session_epoch),
   .rsp_frame_counter    (rsp_frame_counter),
   .rsp_player_slot      (rsp_player_slot),
   .rsp_button_bits      (rsp_button_bits),
   .rsp_stick_horizontal (rsp_stick_horizontal),
   .rsp_stick_vertical   (rsp_stick_vertical)
);
